### design/oled_frame_store_command_decoder_assert.svh
// Assertion macros shared by the frame store decoder modules.
// Both forms sample on the rising clock edge and are disabled while reset is low.
`ifndef OLED_FRAME_STORE_COMMAND_DECODER_ASSERT_SVH
`define OLED_FRAME_STORE_COMMAND_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define OFSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OFSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OFSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define OFSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/ofsd_pkg.sv
package ofsd_pkg;

    // Operation codes carried by the op field of an input item.
    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_READ = 2'd2
    } t_op;

    // Command byte codes.
    localparam logic [7:0] CMD_CONTRAST   = 8'h81;
    localparam logic [7:0] CMD_ALL_ON_OFF = 8'hA4;
    localparam logic [7:0] CMD_ALL_ON     = 8'hA5;
    localparam logic [7:0] CMD_NORMAL     = 8'hA6;
    localparam logic [7:0] CMD_INVERSE    = 8'hA7;
    localparam logic [7:0] CMD_PANEL_OFF  = 8'hAE;
    localparam logic [7:0] CMD_PANEL_ON   = 8'hAF;

    localparam logic [7:0]  CONTRAST_RESET = 8'd127;
    localparam logic [15:0] DIM_NUM        = 16'd48;

    localparam int PIX_X_W = 7;
    localparam int PIX_Y_W = 6;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cmd_en;
        logic wr_en;
        logic rd_en;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

### design/ofsd_ctrl.sv
module ofsd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_op,
    input  ofsd_pkg::t_dp_sts  i_sts,
    output logic               o_in_ready,
    output ofsd_pkg::t_ctrl_cmd o_cmd
);
    import ofsd_pkg::*;

    `include "oled_frame_store_command_decoder_assert.svh"

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        accept     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                accept       = i_in_valid;
                o_cmd.cmd_en = accept && (i_op == OP_CMD);
                o_cmd.wr_en  = accept && (i_op == OP_DATA);
                o_cmd.rd_en  = accept && (i_op == OP_READ);
                if (o_cmd.rd_en) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // The level goes out as soon as the output register is free.
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `OFSD_ASSERT_IMP(a_read_origin, i_clk, i_rst_n,
        (r_state == ST_READ),
        ($past(o_cmd.rd_en) || $past(r_state == ST_READ)),
        "read state entered without an accepted read item")
    `OFSD_ASSERT_NXT(a_read_one_result, i_clk, i_rst_n,
        o_cmd.load_out, (r_state == ST_IDLE),
        "controller stayed in read state after loading a result")
    `OFSD_ASSERT_IMP(a_single_cmd, i_clk, i_rst_n,
        1'b1, $onehot0(o_cmd),
        "more than one datapath command issued in one cycle")

endmodule

### design/ofsd_dp.sv
module ofsd_dp #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ofsd_pkg::t_ctrl_cmd           i_cmd,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    input  logic [ofsd_pkg::PIX_X_W-1:0]  i_pixel_x,
    input  logic [ofsd_pkg::PIX_Y_W-1:0]  i_pixel_y,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [7:0]                    o_pixel_level,
    output ofsd_pkg::t_dp_sts             o_sts
);
    import ofsd_pkg::*;

    `include "oled_frame_store_command_decoder_assert.svh"

    localparam int PAGES = HEIGHT / 8;
    localparam int DEPTH = WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];

    logic [7:0]    r_contrast;
    logic          r_pending;
    logic          r_all_on;
    logic          r_inverse;
    logic          r_enable;

    logic [AW-1:0] r_wr_addr;
    logic [CW-1:0] r_fill;

    logic [7:0]    r_rd_word;
    logic          r_rd_hit;
    logic [2:0]    r_rd_sel;

    logic          r_out_valid;
    logic [7:0]    r_level;

    logic          in_range;
    logic [AW-1:0] rd_addr;
    logic [15:0]   dim_prod;
    logic [15:0]   dim_sum;
    logic [7:0]    dim;
    logic [7:0]    fg;
    logic [7:0]    bg;
    logic          pix_bit;
    logic [7:0]    n_level;

    // Settings registers and command decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast <= CONTRAST_RESET;
            r_pending  <= 1'b0;
            r_all_on   <= 1'b0;
            r_inverse  <= 1'b0;
            r_enable   <= 1'b0;
        end else if (i_cmd.cmd_en) begin
            if (r_pending) begin
                r_contrast <= i_data_byte;
                r_pending  <= 1'b0;
            end else begin
                case (i_data_byte)
                    CMD_CONTRAST:   r_pending <= !i_last_byte;
                    CMD_ALL_ON_OFF: r_all_on  <= 1'b0;
                    CMD_ALL_ON:     r_all_on  <= 1'b1;
                    CMD_NORMAL:     r_inverse <= 1'b0;
                    CMD_INVERSE:    r_inverse <= 1'b1;
                    CMD_PANEL_OFF:  r_enable  <= 1'b0;
                    CMD_PANEL_ON:   r_enable  <= 1'b1;
                    default: begin
                    end
                endcase
            end
        end else if (i_cmd.wr_en) begin
            r_pending <= 1'b0;
        end
    end

    // Data bytes land at consecutive addresses (page * WIDTH + column), so a
    // saturating fill count tells which entries have been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr <= '0;
            r_fill    <= '0;
        end else if (i_cmd.wr_en) begin
            r_wr_addr <= (r_wr_addr == AW'(DEPTH - 1)) ? '0 : r_wr_addr + 1'b1;
            if (r_fill != CW'(DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_comb begin
        in_range = (32'(i_pixel_x) < WIDTH) && (32'(i_pixel_y[PIX_Y_W-1:3]) < PAGES);
        rd_addr  = in_range
                 ? AW'(32'(i_pixel_y[PIX_Y_W-1:3]) * WIDTH + 32'(i_pixel_x))
                 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_wr_addr] <= i_data_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[rd_addr];
            r_rd_hit  <= in_range && (CW'(rd_addr) < r_fill);
            r_rd_sel  <= i_pixel_y[2:0];
        end
    end

    // Background floor(48*contrast/255) via reciprocal; fg if off or all-on.
    always_comb begin
        dim_prod = 16'(r_contrast) * DIM_NUM;
        dim_sum  = dim_prod + (dim_prod >> 8) + 16'd1;
        dim      = dim_sum[15:8];
        fg       = r_enable ? r_contrast : 8'd0;
        bg       = (!r_enable || r_all_on) ? fg : dim;
        pix_bit  = r_rd_hit && r_rd_word[r_rd_sel];
        if (r_inverse) begin
            n_level = pix_bit ? bg : fg;
        end else begin
            n_level = pix_bit ? fg : bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_level <= n_level;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_level  = r_level;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    `OFSD_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n,
        1'b1, (r_fill <= CW'(DEPTH)),
        "fill count beyond frame store depth")
    `OFSD_ASSERT_IMP(a_fill_tracks_addr, i_clk, i_rst_n,
        (r_fill != CW'(DEPTH)), (CW'(r_wr_addr) == r_fill),
        "write address and fill count disagree before the store is full")
    `OFSD_ASSERT_NXT(a_contrast_last, i_clk, i_rst_n,
        (i_cmd.cmd_en && i_last_byte && !r_pending), !r_pending,
        "contrast argument left pending after the last byte of a transfer")

endmodule

### design/oled_frame_store_command_decoder.sv
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_op, i_data_byte, i_last_byte, i_pixel_x, i_pixel_y
// output    o_out_valid / i_out_ready   o_pixel_level
//
// Command and data items may follow back to back.
// A pixel read goes through the frame store read port, then the level logic.
// A read waits in the read state while the output register still holds an untaken item.
// Synchronous active-low reset; the store needs no clearing pass, since a fill count
// marks the entries written since reset and the rest read as clear pixels.
module oled_frame_store_command_decoder #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    input  logic [ofsd_pkg::PIX_X_W-1:0]  i_pixel_x,
    input  logic [ofsd_pkg::PIX_Y_W-1:0]  i_pixel_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_pixel_level
);
    import ofsd_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    ofsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ofsd_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel_level (o_pixel_level),
        .o_sts         (sts)
    );

endmodule
